FILE: rtl/core/lrulc_pkg.sv
// lrulc_pkg: shared types for the lru lookup cache core
// used by lrulc_cell and lru_lookup_cache_core, depends on nothing

package lrulc_pkg;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef struct packed {
    logic compare;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/lrulc_cell.sv
// lrulc_cell: one entry of the recency-ordered chain, holds valid, key and value
// compares its key on a new transfer and loads from its upstream neighbor on shift
// depends on lrulc_pkg

module lrulc_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lrulc_pkg::cell_ctrl_t ctrl_i,
  input  logic [KEY_BITS-1:0]   cmp_key_i,
  input  logic                  up_valid_i,
  input  logic [KEY_BITS-1:0]   up_key_i,
  input  logic [VALUE_BITS-1:0] up_value_i,
  output logic                  valid_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  match_o
);

  logic                  valid_q;
  logic                  valid_d;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  match_q;
  logic                  match_d;

  always_comb begin
    valid_d = ctrl_i.shift ? up_valid_i : valid_q;
    match_d = ctrl_i.compare ? (valid_q && (key_q == cmp_key_i)) : match_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q   <= up_key_i;
      value_q <= up_value_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

FILE: rtl/core/lru_lookup_cache_core.sv
// lru_lookup_cache_core: fully associative key/value cache with lru replacement
// a chain of lrulc_cell entries kept in recency order, cell 0 most recent
// depends on lrulc_pkg and lrulc_cell
//
//   channel  valid        stall        payload
//   in       in_valid_i   in_stall_o   op_i, key_i, write_value_i
//   out      out_valid_o  out_stall_i  hit_o, read_value_o, evicted_o, evicted_key_o
//
// all cells compare their key at the input transfer; then, on a hit or an insert,
// the chain shifts once to move the touched or new entry to cell 0
// a new input transfer is taken once the shift cycle of the previous one is done
// the shift waits while the output register holds a stalled result
// rst_ni clears all valid bits and the handshake state

module lru_lookup_cache_core #(
  parameter int ENTRIES    = 8,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] write_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic                  evicted_o,
  output logic [KEY_BITS-1:0]   evicted_key_o
);

  logic                  in_xfer;
  logic                  fire;
  logic                  pend_q;
  logic                  pend_d;
  lrulc_pkg::op_e        op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  logic                  cell_valid [ENTRIES];
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    below_vec;
  logic [ENTRIES-1:0]    shift_vec;
  logic                  any_hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic [VALUE_BITS-1:0] front_value;
  logic                  is_insert;

  logic                  out_valid_q;
  logic                  out_valid_d;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] read_value_q;
  logic                  evicted_q;
  logic [KEY_BITS-1:0]   evicted_key_q;

  assign in_stall_o = pend_q;
  assign in_xfer    = in_valid_i && !pend_q;
  assign fire       = pend_q && (!out_valid_q || !out_stall_i);
  assign is_insert  = (op_q == lrulc_pkg::OP_INSERT);

  always_comb begin
    pend_d = pend_q;
    if (in_xfer) begin
      pend_d = 1'b1;
    end else if (fire) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= lrulc_pkg::op_e'(op_i);
      key_q   <= key_i;
      value_q <= write_value_i;
    end
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (cell_value[i] & {VALUE_BITS{match_vec[i]}});
    end
  end

  assign any_hit     = |match_vec;
  assign below_vec   = match_vec - ENTRIES'(1);
  assign front_value = is_insert ? value_q : hit_value;

  always_comb begin
    if (any_hit) begin
      shift_vec = match_vec | below_vec;
    end else if (is_insert) begin
      shift_vec = '1;
    end else begin
      shift_vec = '0;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrulc_pkg::cell_ctrl_t ctrl;
    logic                  up_valid;
    logic [KEY_BITS-1:0]   up_key;
    logic [VALUE_BITS-1:0] up_value;

    assign ctrl.compare = in_xfer;
    assign ctrl.shift   = fire && shift_vec[g];

    if (g == 0) begin : g_head
      assign up_valid = 1'b1;
      assign up_key   = key_q;
      assign up_value = front_value;
    end else begin : g_body
      assign up_valid = cell_valid[g-1];
      assign up_key   = cell_key[g-1];
      assign up_value = cell_value[g-1];
    end

    lrulc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .cmp_key_i  (key_i),
      .up_valid_i (up_valid),
      .up_key_i   (up_key),
      .up_value_i (up_value),
      .valid_o    (cell_valid[g]),
      .key_o      (cell_key[g]),
      .value_o    (cell_value[g]),
      .match_o    (match_vec[g])
    );

    assign valid_vec[g] = cell_valid[g];
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q         <= any_hit;
      read_value_q  <= (any_hit && !is_insert) ? hit_value : '0;
      evicted_q     <= !any_hit && is_insert && cell_valid[ENTRIES-1];
      evicted_key_q <= (!any_hit && is_insert && cell_valid[ENTRIES-1])
                       ? cell_key[ENTRIES-1] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = read_value_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;

`ifndef NO_ASSERTIONS
  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> pend_q)
    else $error("accepted transfer did not start the shift cycle");

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("key matched in more than one cell");

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("valid cells are not packed toward cell 0");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("result reports both hit and eviction");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for lru_lookup_cache_core, lookups and inserts
// checked against an lru cache predictor; depends on lrulc_pkg and lru_lookup_cache_core

module tb_top;

  localparam int ENTRIES    = 8;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int AGE_BITS   = 3;
  localparam int POOL_SIZE  = 12;
  localparam int RAND_ITEMS = 1350;
  localparam int QUIET_TAIL = 150;

  typedef struct packed {
    lrulc_pkg::op_e        op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] wval;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } resp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  lrulc_pkg::op_e        drv_op = lrulc_pkg::OP_LOOKUP;
  logic [KEY_BITS-1:0]   drv_key = '0;
  logic [VALUE_BITS-1:0] drv_wval = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  logic                  hit_o;
  logic [VALUE_BITS-1:0] read_value_o;
  logic                  evicted_o;
  logic [KEY_BITS-1:0]   evicted_key_o;

  req_t  req_q[$];
  resp_t resp_q[$];
  req_t  cur;
  resp_t want;
  bit    in_took = 1'b0;
  int    in_gap = 0;
  int    out_gap = 0;
  int    errors = 0;

  // predictor state, age 0 is most recent
  logic                  line_valid [ENTRIES] = '{default: 1'b0};
  logic [KEY_BITS-1:0]   line_key   [ENTRIES] = '{default: '0};
  logic [VALUE_BITS-1:0] line_value [ENTRIES] = '{default: '0};
  logic [AGE_BITS-1:0]   line_age   [ENTRIES] = '{default: '0};

  lru_lookup_cache_core #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .op_i          (drv_op),
    .key_i         (drv_key),
    .write_value_i (drv_wval),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic resp_t cache_access(req_t r);
    resp_t               res;
    int                  found;
    int                  free_idx;
    int                  victim;
    int                  idx;
    logic [AGE_BITS-1:0] old_age;
    res = '0;
    found = -1;
    free_idx = -1;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i]) begin
        if (found < 0 && line_key[i] == r.key) found = i;
        if (victim < 0 || line_age[i] > line_age[victim]) victim = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (r.op == lrulc_pkg::OP_LOOKUP) res.read_value = line_value[found];
      else line_value[found] = r.wval;
      old_age = line_age[found];
      for (int i = 0; i < ENTRIES; i++)
        if (i != found && line_valid[i] && line_age[i] < old_age) line_age[i]++;
      line_age[found] = '0;
      return res;
    end
    if (r.op == lrulc_pkg::OP_LOOKUP) return res;
    if (free_idx >= 0) begin
      idx = free_idx;
    end else begin
      idx = victim;
      res.evicted = 1'b1;
      res.evicted_key = line_key[victim];
    end
    for (int i = 0; i < ENTRIES; i++)
      if (i != idx && line_valid[i]) line_age[i]++;
    line_valid[idx] = 1'b1;
    line_key[idx] = r.key;
    line_value[idx] = r.wval;
    line_age[idx] = '0;
    return res;
  endfunction

  task automatic add_req(lrulc_pkg::op_e op, logic [KEY_BITS-1:0] key,
                         logic [VALUE_BITS-1:0] wval);
    req_t r;
    r.op = op;
    r.key = key;
    r.wval = wval;
    req_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        in_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        cur = req_q.pop_front();
        drv_op <= cur.op;
        drv_key <= cur.key;
        drv_wval <= cur.wval;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (req_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check result transfers, predict on request transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (resp_q.size() == 0) begin
          $display("%0t: result with none expected, hit %b read_value %h evicted %b key %h",
                   $time, hit_o, read_value_o, evicted_o, evicted_key_o);
          errors++;
        end else begin
          want = resp_q.pop_front();
          check_field("hit", 64'(want.hit), 64'(hit_o));
          check_field("read_value", 64'(want.read_value), 64'(read_value_o));
          check_field("evicted", 64'(want.evicted), 64'(evicted_o));
          check_field("evicted_key", 64'(want.evicted_key), 64'(evicted_key_o));
        end
      end
      if (in_valid && !in_stall_o) begin
        resp_q.push_back(cache_access(cur));
        in_took = 1'b1;
      end
    end
  end

  initial begin
    logic [KEY_BITS-1:0] pool [POOL_SIZE];
    logic [KEY_BITS-1:0] k;
    // empty cache, extremes, updates, fill to capacity and lru evictions
    add_req(lrulc_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    add_req(lrulc_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    add_req(lrulc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    add_req(lrulc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    add_req(lrulc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(lrulc_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    add_req(lrulc_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0001);
    add_req(lrulc_pkg::OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    add_req(lrulc_pkg::OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    add_req(lrulc_pkg::OP_INSERT, 32'h0000_0001, 32'h8000_0000);
    add_req(lrulc_pkg::OP_INSERT, 32'h1234_5678, 32'h8765_4321);
    add_req(lrulc_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    add_req(lrulc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    add_req(lrulc_pkg::OP_INSERT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    add_req(lrulc_pkg::OP_INSERT, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
    add_req(lrulc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    add_req(lrulc_pkg::OP_LOOKUP, 32'h5555_5555, 32'hFFFF_FFFF);
    add_req(lrulc_pkg::OP_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    add_req(lrulc_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000);
    add_req(lrulc_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    add_req(lrulc_pkg::OP_INSERT, 32'hFFFF_FFFE, 32'h0000_0000);
    // working set a bit larger than the cache, with stray keys mixed in
    for (int p = 0; p < POOL_SIZE; p++) pool[p] = $urandom;
    repeat (RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) pool[$urandom_range(0, POOL_SIZE-1)] = $urandom;
      if ($urandom_range(0, 6) == 0) k = $urandom;
      else k = pool[$urandom_range(0, POOL_SIZE-1)];
      add_req(lrulc_pkg::op_e'($urandom_range(0, 1)), k, $urandom);
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    while (req_q.size() != 0 || in_valid || resp_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
